[hdl/bbrw_pkg.sv]
package bbrw_pkg;

    localparam int CoordW = 32;
    localparam int AngW   = 16;
    localparam int NumAx  = 3;
    localparam int NumLn  = 2 * NumAx;
    localparam int NumDiv = CoordW + 1;
    localparam int SideN  = NumDiv + 4;

    localparam logic [AngW-1:0] Ang180 = AngW'(32768);
    localparam logic signed [CoordW-1:0] BoxMaxRst = CoordW'(65536000);

    typedef enum logic [1:0] {
        MODE_REFLECT = 2'd0,
        MODE_WRAP    = 2'd1,
        MODE_ERROR   = 2'd2,
        MODE_NONE    = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_MODE  = 3'd0,
        REG_MIN_X = 3'd1,
        REG_MAX_X = 3'd2,
        REG_MIN_Y = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MIN_Z = 3'd5,
        REG_MAX_Z = 3'd6,
        REG_NONE  = 3'd7
    } reg_idx_t;

    // item fields and per axis decisions that ride along the divider
    typedef struct packed {
        logic [NumLn-1:0][CoordW-1:0] coord;
        logic [NumAx-1:0][CoordW-1:0] vel;
        logic [AngW-1:0]              heading;
        logic [AngW-1:0]              elev;
        logic [NumAx-1:0]             refl;
        logic [NumAx-1:0]             wrap;
        logic                         err;
    } side_t;

    // one restoring divider lane
    typedef struct packed {
        logic [CoordW-1:0] rem;
        logic [CoordW:0]   num;
        logic              neg;
        logic              qb;
    } lane_t;

    // one quotient bit of the restoring division
    function automatic lane_t div_step(lane_t l, logic [CoordW-1:0] d);
        lane_t o;
        logic [CoordW:0] r;
        r = {l.rem, l.num[CoordW]};
        o = l;
        o.num = {l.num[CoordW-1:0], 1'b0};
        if (r >= {1'b0, d}) begin
            o.rem = CoordW'(r - {1'b0, d});
            o.qb = 1'b1;
        end else begin
            o.rem = r[CoordW-1:0];
            o.qb = 1'b0;
        end
        return o;
    endfunction

endpackage

[hdl/box_border_reflect_wrap_unit.sv]
// box border handling for one moving object per transfer
// s_ channel: position, target, velocity, heading and elevation in tdata
// m_ channel: folded position and target, velocity, angles in tdata, error flag in tuser
// cfg channel: register index and data; cfg_ready is always high, write only when idle
// per axis outside a box with max above min, reflect folds position and target by
// floor-modulo of the box size, mirroring an odd fold and reflecting velocity and angles,
// wrap applies a periodic modulo; per axis outside any box, error mode raises the flag
// pipeline stages: input register, offset stage, 33 restoring divider
// stages (one quotient bit each, six lanes in parallel), two fixup stages
// and the output register
// throughput is one transfer per cycle while m_tready does not stall the pipe;
// all stages advance together when the output register is empty or taken,
// so a stall on m_tready freezes the whole pipe and loses nothing
// synchronous active-low reset clears valid bits and restores the default box
module box_border_reflect_wrap_unit (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // pos_x, pos_y, pos_z, goal_x, goal_y, goal_z, vel_x, vel_y, vel_z,
    // heading_in, elevation_in
    input  logic [319:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // new_pos_x, new_pos_y, new_pos_z, new_goal_x, new_goal_y, new_goal_z,
    // new_vel_x, new_vel_y, new_vel_z, heading_out, elevation_out
    output logic [319:0] m_tdata,
    // outside_error
    output logic [0:0]   m_tuser,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_addr,
    input  logic [31:0]  cfg_data
);

    localparam int W  = bbrw_pkg::CoordW;
    localparam int AW = bbrw_pkg::AngW;
    localparam int NA = bbrw_pkg::NumAx;
    localparam int NL = bbrw_pkg::NumLn;
    localparam int ND = bbrw_pkg::NumDiv;
    localparam int SN = bbrw_pkg::SideN;

    // configuration registers
    bbrw_pkg::mode_t           mode_reg;
    logic [NA-1:0][W-1:0]      min_reg;
    logic [NA-1:0][W-1:0]      max_reg;
    logic [NA-1:0][W-1:0]      size;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= bbrw_pkg::MODE_REFLECT;
            for (int a = 0; a < NA; a++) begin
                min_reg[a] <= '0;
                max_reg[a] <= bbrw_pkg::BoxMaxRst;
            end
        end else if (cfg_valid) begin
            case (bbrw_pkg::reg_idx_t'(cfg_addr))
                bbrw_pkg::REG_MODE:  mode_reg <= bbrw_pkg::mode_t'(cfg_data[1:0]);
                bbrw_pkg::REG_MIN_X: min_reg[0] <= cfg_data;
                bbrw_pkg::REG_MAX_X: max_reg[0] <= cfg_data;
                bbrw_pkg::REG_MIN_Y: min_reg[1] <= cfg_data;
                bbrw_pkg::REG_MAX_Y: max_reg[1] <= cfg_data;
                bbrw_pkg::REG_MIN_Z: min_reg[2] <= cfg_data;
                bbrw_pkg::REG_MAX_Z: max_reg[2] <= cfg_data;
                default: ;
            endcase
        end
    end

    // box size per axis, only meaningful when max is above min
    always_comb begin
        for (int a = 0; a < NA; a++) size[a] = max_reg[a] - min_reg[a];
    end

    // pipeline state
    logic                    adv;
    logic [SN-1:0]           vld_reg;
    bbrw_pkg::side_t         side_reg [SN];
    logic [NL-1:0]           nz;
    bbrw_pkg::lane_t [NL-1:0] lane0_next;
    bbrw_pkg::lane_t [NL-1:0] lane_reg [ND+1];
    bbrw_pkg::lane_t [NL-1:0] lane_next [ND+1];
    logic [NL-1:0][W-1:0]    fix_reg;
    logic [NL-1:0]           fodd_reg;
    logic [NL-1:0][W-1:0]    fix_next;
    logic [NL-1:0]           fodd_next;
    logic [NL-1:0][W-1:0]    mod_reg;
    logic [NL-1:0]           modd_reg;
    logic [NL-1:0][W-1:0]    mod_next;
    bbrw_pkg::side_t         in_side;
    bbrw_pkg::side_t         prep_side;
    logic                    out_vld_reg;
    logic [319:0]            out_data_reg;
    logic [319:0]            out_data_next;
    logic                    out_err_reg;

    assign adv      = !out_vld_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_err_reg;

    // unpack the input transfer
    always_comb begin
        in_side = '0;
        for (int i = 0; i < NL; i++) in_side.coord[i] = s_tdata[i*W +: W];
        for (int a = 0; a < NA; a++) in_side.vel[a] = s_tdata[(NL+a)*W +: W];
        in_side.heading = s_tdata[(NL+NA)*W +: AW];
        in_side.elev    = s_tdata[(NL+NA)*W+AW +: AW];
    end

    // offset from the lower bound, magnitude and border decisions
    always_comb begin
        logic [W:0] v;
        logic outside;
        logic proper;
        prep_side = side_reg[0];
        prep_side.err = 1'b0;
        for (int a = 0; a < NA; a++) begin
            outside = ($signed(side_reg[0].coord[a]) < $signed(min_reg[a])) ||
                      ($signed(side_reg[0].coord[a]) > $signed(max_reg[a]));
            proper  = $signed(max_reg[a]) > $signed(min_reg[a]);
            prep_side.refl[a] = outside && proper && (mode_reg == bbrw_pkg::MODE_REFLECT);
            prep_side.wrap[a] = outside && proper && (mode_reg == bbrw_pkg::MODE_WRAP);
            if (outside && (mode_reg == bbrw_pkg::MODE_ERROR)) prep_side.err = 1'b1;
        end
        for (int i = 0; i < NL; i++) begin
            v = {side_reg[0].coord[i][W-1], side_reg[0].coord[i]} -
                {min_reg[i % NA][W-1], min_reg[i % NA]};
            lane0_next[i].neg = v[W];
            lane0_next[i].num = v[W] ? (W+1)'(-v) : v;
            lane0_next[i].rem = '0;
            lane0_next[i].qb  = 1'b0;
        end
    end

    // divider stages
    always_comb begin
        lane_next[0] = lane0_next;
        for (int k = 1; k <= ND; k++) begin
            for (int i = 0; i < NL; i++) begin
                lane_next[k][i] = bbrw_pkg::div_step(lane_reg[k-1][i], size[i % NA]);
            end
        end
    end

    // floor remainder and fold parity
    always_comb begin
        for (int i = 0; i < NL; i++) begin
            nz[i] = lane_reg[ND][i].rem != '0;
            fix_next[i] = (lane_reg[ND][i].neg && nz[i]) ?
                          size[i % NA] - lane_reg[ND][i].rem : lane_reg[ND][i].rem;
            fodd_next[i] = lane_reg[ND][i].qb ^ (lane_reg[ND][i].neg && nz[i]);
        end
    end

    // mirrored remainder on an odd fold
    always_comb begin
        for (int i = 0; i < NL; i++) begin
            if (side_reg[SN-2].refl[i % NA] && fodd_reg[i] && fix_reg[i] != '0)
                mod_next[i] = size[i % NA] - fix_reg[i];
            else
                mod_next[i] = fix_reg[i];
        end
    end

    // final values
    always_comb begin
        bbrw_pkg::side_t s;
        logic [AW-1:0] h;
        logic [AW-1:0] e;
        s = side_reg[SN-1];
        h = s.heading;
        e = s.elev;
        out_data_next = '0;
        for (int i = 0; i < NL; i++) begin
            if (s.refl[i % NA] || s.wrap[i % NA])
                out_data_next[i*W +: W] = mod_reg[i] + min_reg[i % NA];
            else
                out_data_next[i*W +: W] = s.coord[i];
        end
        for (int a = 0; a < NA; a++) begin
            if (s.refl[a] && modd_reg[a])
                out_data_next[(NL+a)*W +: W] = (s.vel[a] == {1'b1, {(W-1){1'b0}}}) ?
                                               {1'b0, {(W-1){1'b1}}} : W'(-s.vel[a]);
            else
                out_data_next[(NL+a)*W +: W] = s.vel[a];
        end
        if (s.refl[0] && modd_reg[0]) h = bbrw_pkg::Ang180 - h;
        if (s.refl[1] && modd_reg[1]) h = AW'(-h);
        if (s.refl[2] && modd_reg[2]) e = AW'(-e);
        out_data_next[(NL+NA)*W +: AW]    = h;
        out_data_next[(NL+NA)*W+AW +: AW] = e;
    end

    // valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg     <= '0;
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            vld_reg     <= {vld_reg[SN-2:0], s_tvalid};
            out_vld_reg <= vld_reg[SN-1];
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (adv) begin
            side_reg[0] <= in_side;
            side_reg[1] <= prep_side;
            for (int k = 2; k < SN; k++) side_reg[k] <= side_reg[k-1];
            for (int k = 0; k <= ND; k++) lane_reg[k] <= lane_next[k];
            fix_reg      <= fix_next;
            fodd_reg     <= fodd_next;
            mod_reg      <= mod_next;
            modd_reg     <= fodd_reg;
            out_data_reg <= out_data_next;
            out_err_reg  <= side_reg[SN-1].err;
        end
    end

    // checks
    a_reset_clears: assert property (@(posedge aclk) !aresetn |=> !m_tvalid && vld_reg == '0)
        else $error("valid bits not cleared by reset");
    a_stall_freezes: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(vld_reg) && $stable(out_data_reg))
        else $error("pipeline moved during stall");
    a_err_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[SN-1] && side_reg[SN-1].err |->
        side_reg[SN-1].refl == '0 && side_reg[SN-1].wrap == '0)
        else $error("error flag together with fold");
    a_mode_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        vld_reg[SN-1] |-> (side_reg[SN-1].refl & side_reg[SN-1].wrap) == '0)
        else $error("reflect and wrap on one axis");

endmodule

[bench/box_border_reflect_wrap_unit_test.sv]
`timescale 1ns / 1ps

module box_border_reflect_wrap_unit_test;

    typedef struct packed {
        logic [15:0]        elev;
        logic [15:0]        heading;
        logic [2:0][31:0]   vel;
        logic [2:0][31:0]   goal;
        logic [2:0][31:0]   pos;
    } motion_t;

    typedef struct {
        motion_t m;
        logic    err;
    } border_result_t;

    // expected border results in arrival order
    class border_scoreboard;
        border_result_t pending[$];
        int             mismatches;

        task report(string msg);
            $display("error: %s", msg);
            mismatches++;
        endtask

        function void note_item(border_result_t r);
            pending.push_back(r);
        endfunction

        task check_result(motion_t got, logic got_err);
            border_result_t e;
            if (pending.size() == 0) begin
                report("result with nothing pending");
                return;
            end
            e = pending.pop_front();
            for (int a = 0; a < 3; a++) begin
                if (got.pos[a] !== e.m.pos[a])
                    report($sformatf("pos[%0d] got %h exp %h", a, got.pos[a], e.m.pos[a]));
                if (got.goal[a] !== e.m.goal[a])
                    report($sformatf("goal[%0d] got %h exp %h", a, got.goal[a], e.m.goal[a]));
                if (got.vel[a] !== e.m.vel[a])
                    report($sformatf("vel[%0d] got %h exp %h", a, got.vel[a], e.m.vel[a]));
            end
            if (got.heading !== e.m.heading)
                report($sformatf("heading got %h exp %h", got.heading, e.m.heading));
            if (got.elev !== e.m.elev)
                report($sformatf("elevation got %h exp %h", got.elev, e.m.elev));
            if (got_err !== e.err)
                report($sformatf("outside flag got %b exp %b", got_err, e.err));
        endtask
    endclass

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [319:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [319:0] m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [2:0]   cfg_addr;
    logic [31:0]  cfg_data;

    box_border_reflect_wrap_unit u_dut (.*);

    border_scoreboard sb = new();

    // copy of the box configuration
    bbrw_pkg::mode_t         cur_mode;
    logic signed [31:0]      box_lo [3];
    logic signed [31:0]      box_hi [3];

    int send_idle_pct;
    int recv_stall_pct;
    bit hold_off;

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    // floor modulo, quotient returned through q
    function automatic longint floor_mod(longint v, longint sz, output longint q);
        longint r;
        q = v / sz;
        r = v % sz;
        if (r < 0) begin
            r += sz;
            q -= 1;
        end
        return r;
    endfunction

    function automatic logic [31:0] fold_reflect(logic signed [31:0] lo,
                                                 logic signed [31:0] hi,
                                                 logic signed [31:0] c, output bit odd);
        longint sz, v, q, r;
        sz = longint'(hi) - longint'(lo);
        v = longint'(c) - longint'(lo);
        r = floor_mod(v, sz, q);
        odd = q[0];
        if (odd)
            v = -v;
        r = floor_mod(v, sz, q);
        return 32'(r + longint'(lo));
    endfunction

    function automatic logic [31:0] fold_wrap(logic signed [31:0] lo,
                                              logic signed [31:0] hi,
                                              logic signed [31:0] c);
        longint q;
        return 32'(floor_mod(longint'(c) - longint'(lo), longint'(hi) - longint'(lo), q)
                   + longint'(lo));
    endfunction

    function automatic border_result_t predict_border(motion_t in);
        border_result_t r;
        logic signed [31:0] p;
        bit outside, odd, dummy;
        r.m = in;
        r.err = 1'b0;
        for (int a = 0; a < 3; a++) begin
            p = in.pos[a];
            outside = (p < box_lo[a]) || (p > box_hi[a]);
            if (!outside)
                continue;
            if (cur_mode == bbrw_pkg::MODE_ERROR) begin
                r.err = 1'b1;
            end else if (cur_mode == bbrw_pkg::MODE_REFLECT && box_hi[a] > box_lo[a]) begin
                r.m.pos[a] = fold_reflect(box_lo[a], box_hi[a], in.pos[a], odd);
                r.m.goal[a] = fold_reflect(box_lo[a], box_hi[a], in.goal[a], dummy);
                if (odd) begin
                    r.m.vel[a] = (in.vel[a] == 32'h8000_0000) ? 32'h7fff_ffff
                                                               : -in.vel[a];
                    if (a == 0)
                        r.m.heading = bbrw_pkg::Ang180 - r.m.heading;
                    else if (a == 1)
                        r.m.heading = -r.m.heading;
                    else
                        r.m.elev = -r.m.elev;
                end
            end else if (cur_mode == bbrw_pkg::MODE_WRAP && box_hi[a] > box_lo[a]) begin
                r.m.pos[a] = fold_wrap(box_lo[a], box_hi[a], in.pos[a]);
                r.m.goal[a] = fold_wrap(box_lo[a], box_hi[a], in.goal[a]);
            end
        end
        return r;
    endfunction

    // check each result transfer
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(motion_t'(m_tdata), m_tuser[0]);
    end

    // receiver backpressure
    always @(posedge aclk) begin
        if (!aresetn)
            m_tready <= 1'b0;
        else
            m_tready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_reg(bbrw_pkg::reg_idx_t idx, logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            bbrw_pkg::REG_MODE:  cur_mode = bbrw_pkg::mode_t'(val[1:0]);
            bbrw_pkg::REG_MIN_X: box_lo[0] = val;
            bbrw_pkg::REG_MAX_X: box_hi[0] = val;
            bbrw_pkg::REG_MIN_Y: box_lo[1] = val;
            bbrw_pkg::REG_MAX_Y: box_hi[1] = val;
            bbrw_pkg::REG_MIN_Z: box_lo[2] = val;
            bbrw_pkg::REG_MAX_Z: box_hi[2] = val;
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_box(bbrw_pkg::mode_t md, logic [31:0] lo, logic [31:0] hi);
        write_reg(bbrw_pkg::REG_MODE, 32'(md));
        write_reg(bbrw_pkg::REG_MIN_X, lo);
        write_reg(bbrw_pkg::REG_MAX_X, hi);
        write_reg(bbrw_pkg::REG_MIN_Y, lo);
        write_reg(bbrw_pkg::REG_MAX_Y, hi + 32'h0001_8000);
        write_reg(bbrw_pkg::REG_MIN_Z, lo - 32'h0000_4000);
        write_reg(bbrw_pkg::REG_MAX_Z, hi);
    endtask

    task automatic send_item(motion_t m);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= m;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        sb.note_item(predict_border(m));
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (sb.pending.size() != 0)
            @(posedge aclk);
        repeat (45) @(posedge aclk);
    endtask

    // coordinate near the box or anywhere
    function automatic logic [31:0] rand_coord(logic signed [31:0] lo,
                                               logic signed [31:0] hi);
        logic signed [31:0] span;
        case ($urandom_range(5))
            0: return $urandom();
            1: return lo - 32'($urandom_range(4096));
            2: return hi + 32'($urandom_range(4096));
            3: return ($urandom_range(1)) ? 32'h8000_0000 : 32'h7fff_ffff;
            default: begin
                span = hi - lo;
                return lo + 32'($urandom()) % (span == 0 ? 32'd1 : span) * 3 - span;
            end
        endcase
    endfunction

    function automatic motion_t rand_motion();
        motion_t m;
        for (int a = 0; a < 3; a++) begin
            m.pos[a] = rand_coord(box_lo[a], box_hi[a]);
            m.goal[a] = ($urandom_range(1)) ? rand_coord(box_lo[a], box_hi[a]) : $urandom();
            m.vel[a] = ($urandom_range(9) == 0) ? 32'h8000_0000 : $urandom();
        end
        m.heading = 16'($urandom());
        m.elev = 16'($urandom());
        return m;
    endfunction

    task automatic run_random(int n);
        for (int i = 0; i < n; i++)
            send_item(rand_motion());
    endtask

    initial begin
        motion_t m;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_addr = bbrw_pkg::REG_MODE;
        cfg_data = '0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        cur_mode = bbrw_pkg::MODE_REFLECT;
        for (int a = 0; a < 3; a++) begin
            box_lo[a] = 0;
            box_hi[a] = bbrw_pkg::BoxMaxRst;
        end
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: reset box, field extremes
        for (int k = 0; k < 6; k++) begin
            m = '0;
            for (int a = 0; a < 3; a++) begin
                m.pos[a] = (k == 0) ? 32'h8000_0000 : (k == 1) ? 32'h7fff_ffff :
                           (k == 2) ? bbrw_pkg::BoxMaxRst : (k == 3) ? -32'sd1 :
                           (k == 4) ? bbrw_pkg::BoxMaxRst + 1 :
                           bbrw_pkg::BoxMaxRst * 2 + 5;
                m.goal[a] = ~m.pos[a];
                m.vel[a] = (k[0]) ? 32'h8000_0000 : 32'h7fff_ffff;
            end
            m.heading = k[0] ? 16'hffff : 16'h0000;
            m.elev = k[1] ? 16'hffff : 16'h4000;
            send_item(m);
        end
        drain();

        // every mode, including the unused one, and a degenerate x axis
        for (int md = 0; md < 4; md++) begin
            set_box(bbrw_pkg::mode_t'(md), 32'hffff_0000, 32'h0003_0000);
            write_reg(bbrw_pkg::REG_MAX_Z, 32'hffff_0000);
            write_reg(bbrw_pkg::REG_MIN_X, 32'h0005_0000);
            for (int k = 0; k < 4; k++)
                send_item(rand_motion());
            drain();
        end

        // extreme boxes and random phases
        for (int ph = 0; ph < 12; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 65; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 65; end
                default: begin send_idle_pct = 21; recv_stall_pct = 21; end
            endcase
            case (ph % 3)
                0: set_box(bbrw_pkg::mode_t'(ph % 3), 32'h8000_0000, 32'h7fff_ffff);
                1: set_box(bbrw_pkg::mode_t'(ph % 3), 32'hfff0_0000, 32'h0000_0003);
                default: set_box(bbrw_pkg::mode_t'(ph % 3), $urandom(), $urandom());
            endcase
            if (ph == 4)
                set_box(bbrw_pkg::MODE_REFLECT, 32'hffff_0000, 32'h0002_0000);
            if (ph == 5) begin
                // long receiver hold-off while items keep coming
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(posedge aclk);
                        hold_off = 1'b0;
                    end
                    run_random(110);
                join
            end else begin
                run_random(110);
            end
            // sender waits for every result before the next phase
            drain();
        end

        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    initial begin
        #5_000_000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule
